>>> rtl/kwm_pkg.sv
// Shared types, constants and the heap key compare for the k-way merge block.
// Depends on nothing; kwm_if and k_way_merge_heap import it.

package kwm_pkg;

	localparam int SRC_W = 4;
	localparam int VAL_W = 32;
	localparam int CNT_W = 5;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [SRC_W-1:0] src;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UP_RD,
		ST_UP_CMP,
		ST_UP_WR,
		ST_DECIDE,
		ST_POP_ROOT,
		ST_POP_LAST,
		ST_DN_RDL,
		ST_DN_RDR,
		ST_DN_CMP,
		ST_EMIT
	} kwm_state_t;

	// Heap order: smaller value first, lower list index on equal values.
	function automatic logic key_less(entry_t a, entry_t b);
		logic res;
		if (a.value != b.value) begin
			res = (a.value < b.value);
		end else begin
			res = (a.src < b.src);
		end
		return res;
	endfunction

endpackage

>>> rtl/kwm_if.sv
// Valid/ready channel interfaces for the k-way merge block.
// Depends on kwm_pkg for the field widths.

interface kwm_in_if import kwm_pkg::*; ();
	logic valid;
	logic ready;
	logic [SRC_W-1:0] source;
	logic signed [VAL_W-1:0] element;
	logic present;

	modport src_end (output valid, source, element, present, input ready);
	modport sink_end (input valid, source, element, present, output ready);
endinterface

interface kwm_out_if import kwm_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [VAL_W-1:0] smallest;
	logic [SRC_W-1:0] from_list;
	logic done_res;

	modport src_end (output valid, smallest, from_list, done_res, input ready);
	modport sink_end (input valid, smallest, from_list, done_res, output ready);
endinterface

>>> rtl/kwm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.

module kwm_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/k_way_merge_heap.sv
// K-way merge of sorted signed lists through a min-heap kept in one RAM.
// Depends on kwm_pkg, kwm_in_if / kwm_out_if and kwm_ram.
//
// Usage: set list_count through cfg_we/cfg_wdata while the block is idle.
// On the feed channel the host first sends one beat per list with its head
// element (present high) or with present low for an empty list. These beats
// give no result. The beat that completes the load, and every later beat,
// gives one result beat on the merged channel: the smallest remaining value
// and the list it came from. The host answers with that list's next element
// or with present low once it is exhausted. When the heap runs empty a single
// beat with done_res high is sent and the block is ready for a new merge.
// The block works on one beat at a time. An insert climbs the heap level by
// level (RAM read, then compare and write) and ends with a write of the root
// if it gets there; a pop descends level by level (read left, read right,
// compare and write) after it has read the root and the last entry.
// The result sits in an output register, so a stalled receiver does not block
// the next feed beat; a further result waits until the register is taken.
// Reset empties the heap, returns to the load phase and sets list_count to 1.

module k_way_merge_heap import kwm_pkg::*; #(
	parameter int MAX_LISTS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	kwm_in_if.sink_end       feed,
	kwm_out_if.src_end       merged
);

	localparam int AW = $clog2(MAX_LISTS);
	localparam int SW = $clog2(MAX_LISTS + 1);

	kwm_state_t state_q, state_d;

	logic [SW-1:0]    size_q;
	logic [CNT_W-1:0] heads_loaded_q;
	logic             merging_q;
	logic [CNT_W-1:0] list_count_q;
	entry_t           key_q;
	entry_t           best_q;
	logic             best_child_q;
	logic [AW-1:0]    best_idx_q;
	logic [AW-1:0]    idx_q;
	entry_t           res_q;
	logic             res_done_q;
	logic             out_valid_q;
	entry_t           out_q;
	logic             out_done_q;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [ENTRY_W-1:0]   ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [ENTRY_W-1:0]   ram_rdata;
	entry_t               rd_entry;

	logic                 accept;
	logic                 do_insert;
	entry_t               in_entry;
	logic [AW-1:0]        parent_idx;
	logic [SW:0]          left_w;
	logic [SW:0]          right_w;
	logic                 left_ok;
	logic                 right_ok;
	logic [CNT_W-1:0]     hl_next;
	logic [CNT_W-1:0]     lc_eff;
	logic                 load_done;
	logic                 emit_load;

	kwm_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_LISTS)
	) u_heap_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_entry = entry_t'(ram_rdata);
	assign in_entry = '{value: feed.element, src: feed.source};

	assign feed.ready = (state_q == ST_IDLE);
	assign accept = feed.valid && feed.ready;
	assign do_insert = feed.present && (size_q < SW'(MAX_LISTS));

	assign parent_idx = (idx_q - AW'(1)) >> 1;
	assign left_w = ((SW+1)'(idx_q) << 1) + (SW+1)'(1);
	assign right_w = left_w + (SW+1)'(1);
	assign left_ok = (left_w < (SW+1)'(size_q));
	assign right_ok = (right_w < (SW+1)'(size_q));

	// A list_count of zero counts as one list; the heap depth caps it from above.
	assign hl_next = heads_loaded_q + CNT_W'(1);
	assign lc_eff = (list_count_q == '0) ? CNT_W'(1) : list_count_q;
	assign load_done = (hl_next >= lc_eff) || (32'(hl_next) >= 32'(MAX_LISTS));

	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || merged.ready);

	assign merged.valid = out_valid_q;
	assign merged.smallest = out_q.value;
	assign merged.from_list = out_q.src;
	assign merged.done_res = out_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and RAM control. The hole method moves entries instead of
	// swapping them, so the key being placed is written only once.
	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ENTRY_W'(key_q);
		ram_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (do_insert) begin
						if (size_q == '0) begin
							ram_we = 1'b1;
							ram_waddr = '0;
							ram_wdata = ENTRY_W'(in_entry);
							state_d = ST_DECIDE;
						end else begin
							state_d = ST_UP_RD;
						end
					end else begin
						state_d = ST_DECIDE;
					end
				end
			end
			ST_UP_RD: begin
				ram_raddr = parent_idx;
				state_d = ST_UP_CMP;
			end
			ST_UP_CMP: begin
				ram_we = 1'b1;
				ram_waddr = idx_q;
				if (key_less(key_q, rd_entry)) begin
					ram_wdata = ram_rdata;
					state_d = (parent_idx == '0) ? ST_UP_WR : ST_UP_RD;
				end else begin
					ram_wdata = ENTRY_W'(key_q);
					state_d = ST_DECIDE;
				end
			end
			ST_UP_WR: begin
				ram_we = 1'b1;
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				ram_raddr = '0;
				if (!merging_q && !load_done) begin
					state_d = ST_IDLE;
				end else if (size_q == '0) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_POP_ROOT;
				end
			end
			ST_POP_ROOT: begin
				ram_raddr = AW'(size_q - SW'(1));
				state_d = (size_q == SW'(1)) ? ST_EMIT : ST_POP_LAST;
			end
			ST_POP_LAST: begin
				state_d = ST_DN_RDL;
			end
			ST_DN_RDL: begin
				ram_raddr = left_w[AW-1:0];
				if (left_ok) begin
					state_d = ST_DN_RDR;
				end else begin
					ram_we = 1'b1;
					state_d = ST_EMIT;
				end
			end
			ST_DN_RDR: begin
				ram_raddr = right_w[AW-1:0];
				state_d = ST_DN_CMP;
			end
			ST_DN_CMP: begin
				ram_we = 1'b1;
				if (right_ok && key_less(rd_entry, best_q)) begin
					ram_wdata = ram_rdata;
					state_d = ST_DN_RDL;
				end else if (best_child_q) begin
					ram_wdata = ENTRY_W'(best_q);
					state_d = ST_DN_RDL;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
			heads_loaded_q <= '0;
			merging_q <= 1'b0;
			list_count_q <= CNT_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				list_count_q <= cfg_wdata;
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (merged.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept && do_insert) begin
				size_q <= size_q + SW'(1);
			end
			if (state_q == ST_POP_ROOT) begin
				size_q <= size_q - SW'(1);
			end
			if (state_q == ST_DECIDE) begin
				if (!merging_q) begin
					heads_loaded_q <= hl_next;
					if (load_done) begin
						merging_q <= 1'b1;
					end
				end
				if ((merging_q || load_done) && size_q == '0) begin
					heads_loaded_q <= '0;
					merging_q <= 1'b0;
				end
			end
		end
	end

	// Datapath registers: no reset needed.
	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_q <= res_q;
			out_done_q <= res_done_q;
		end
		case (state_q)
			ST_IDLE: begin
				key_q <= in_entry;
				idx_q <= size_q[AW-1:0];
			end
			ST_UP_CMP: begin
				idx_q <= parent_idx;
			end
			ST_DECIDE: begin
				res_q <= '0;
				res_done_q <= 1'b1;
			end
			ST_POP_ROOT: begin
				res_q <= rd_entry;
				res_done_q <= 1'b0;
			end
			ST_POP_LAST: begin
				key_q <= rd_entry;
				idx_q <= '0;
			end
			ST_DN_RDR: begin
				if (key_less(rd_entry, key_q)) begin
					best_q <= rd_entry;
					best_child_q <= 1'b1;
				end else begin
					best_q <= key_q;
					best_child_q <= 1'b0;
				end
				best_idx_q <= left_w[AW-1:0];
			end
			ST_DN_CMP: begin
				if (right_ok && key_less(rd_entry, best_q)) begin
					idx_q <= right_w[AW-1:0];
				end else if (best_child_q) begin
					idx_q <= best_idx_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(size_q) <= 32'(MAX_LISTS))
		else $error("heap size above capacity");

	a_write_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (32'($past(ram_waddr)) < 32'(size_q)))
		else $error("heap write outside the occupied entries");

	a_done_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_load && res_done_q) |=> (!merging_q && heads_loaded_q == '0 && size_q == '0))
		else $error("done beat sent while a merge is still open");

endmodule
